// ===== rtl/ttd_pkg.sv =====
`timescale 1ns / 1ps

package ttd_pkg;

    // Table size and time counter width.
    localparam int NUM_TASKS = 4;
    localparam int TIME_BITS = 32;

    // Scan pointer width; at least one bit even for a single task.
    localparam int PTR_BITS = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    // Stream payload widths; the tdata widths are padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [PTR_BITS-1:0]  ptr_t;

    // Request kinds carried in the slave tuser.
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_POLL  = 2'd1,
        REQ_SCHED = 2'd2,
        REQ_DONE  = 2'd3
    } req_type_t;

    // One request as held in the input register.
    typedef struct packed {
        req_type_t   req_type;
        logic [1:0]  task_index;
        logic [31:0] delay;
    } req_t;

    // One result as formed by the scheduler core.
    typedef struct packed {
        logic        status;
        logic [31:0] current_time;
        logic [1:0]  dispatched_task;
        logic        dispatched;
    } res_t;

endpackage

// ===== rtl/ttd_core.sv =====
`timescale 1ns / 1ps

module ttd_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  ttd_pkg::req_t req,
    output ttd_pkg::res_t res
);

    localparam ttd_pkg::ptr_t PTR_LAST = ttd_pkg::PTR_BITS'(ttd_pkg::NUM_TASKS - 1);

    ttd_pkg::time_t tick_reg, tick_next;
    ttd_pkg::time_t due_reg  [ttd_pkg::NUM_TASKS];
    ttd_pkg::time_t due_next [ttd_pkg::NUM_TASKS];
    ttd_pkg::ptr_t  ptr_reg, ptr_next;
    logic           wait_reg, wait_next;

    ttd_pkg::time_t entry;
    ttd_pkg::time_t dly;
    ttd_pkg::time_t sum;
    ttd_pkg::ptr_t  ptr_adv;
    ttd_pkg::ptr_t  sched_idx;
    logic           entry_due;
    logic           bad_index;

    // Shared datapath: entry at the pointer, due test and wrapped due sum.
    assign entry     = due_reg[ptr_reg];
    assign entry_due = (entry != '0) && (tick_reg >= entry);
    assign dly       = ttd_pkg::TIME_BITS'(req.delay);
    assign sum       = tick_reg + dly;
    assign ptr_adv   = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
    assign sched_idx = ttd_pkg::PTR_BITS'(req.task_index);
    assign bad_index = (32'(req.task_index) >= 32'(ttd_pkg::NUM_TASKS));

    // Next state and result for the request in the input register.
    always_comb
    begin
        tick_next = tick_reg;
        due_next  = due_reg;
        ptr_next  = ptr_reg;
        wait_next = wait_reg;
        res.dispatched      = 1'b0;
        res.dispatched_task = 2'(ptr_reg);
        res.status          = 1'b0;
        if (go)
        begin
            unique case (req.req_type)
                ttd_pkg::REQ_TICK:
                begin
                    tick_next = tick_reg + 1'b1;
                end
                ttd_pkg::REQ_POLL:
                begin
                    if (wait_reg)
                    begin
                        res.status = 1'b1;
                    end
                    else if (entry_due)
                    begin
                        res.dispatched = 1'b1;
                        wait_next      = 1'b1;
                    end
                    else
                    begin
                        ptr_next = ptr_adv;
                    end
                end
                ttd_pkg::REQ_SCHED:
                begin
                    res.dispatched_task = req.task_index;
                    if (bad_index)
                    begin
                        res.status = 1'b1;
                    end
                    else
                    begin
                        due_next[sched_idx] = sum;
                    end
                end
                ttd_pkg::REQ_DONE:
                begin
                    if (!wait_reg)
                    begin
                        res.status = 1'b1;
                    end
                    else
                    begin
                        due_next[ptr_reg] = (dly != '0) ? sum : '0;
                        wait_next         = 1'b0;
                        ptr_next          = ptr_adv;
                    end
                end
                default:
                begin
                    res.status = 1'b1;
                end
            endcase
        end
        res.current_time = 32'(tick_next);
    end

    // Scheduler state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= ttd_pkg::TIME_BITS'(1);
            due_reg  <= '{default: '0};
            ptr_reg  <= '0;
            wait_reg <= 1'b0;
        end
        else
        begin
            tick_reg <= tick_next;
            due_reg  <= due_next;
            ptr_reg  <= ptr_next;
            wait_reg <= wait_next;
        end
    end

    // A dispatch always leaves the core waiting for the task to finish.
    a_dispatch_waits: assert property (@(posedge clk) disable iff (!rst_n)
        go && res.dispatched |=> wait_reg)
        else $error("dispatch did not set the waiting flag");

    // A dispatch only happens for an armed entry.
    a_dispatch_armed: assert property (@(posedge clk) disable iff (!rst_n)
        go && res.dispatched |-> (entry != '0) && !wait_reg)
        else $error("dispatch of an idle entry or while busy");

    // The pointer holds while a dispatched task is pending.
    a_ptr_holds: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg && !(go && req.req_type == ttd_pkg::REQ_DONE) |=> $stable(ptr_reg))
        else $error("scan pointer moved while a task was pending");

    // Time only moves on a tick request.
    a_time_steps: assert property (@(posedge clk) disable iff (!rst_n)
        !(go && req.req_type == ttd_pkg::REQ_TICK) |=> $stable(tick_reg))
        else $error("tick counter changed without a tick request");

endmodule

// ===== rtl/tick_task_dispatcher.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tuser: req_type; s_tdata: task_index, delay
// m_*       out        m_tvalid/m_tready  m_tdata: dispatched, dispatched_task,
//                                         current_time, status
//
// Every request yields exactly one result; one request is taken per cycle while
// the result side is not stalled. Requests pass an input register, then the
// scheduler core feeding a result register. The core reads and writes its due
// table in the same cycle. Reset empties both registers, sets time to one and
// idles every task. A stalled result register holds the core; the input register
// keeps taking a request while the result waits only if it is itself empty.

module tick_task_dispatcher
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] task_index, [33:2] delay, [39:34] zero
    input  logic [ttd_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [ttd_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] dispatched, [2:1] dispatched_task, [34:3] current_time, [35] status,
    // [39:36] zero
    output logic [ttd_pkg::M_TDATA_W-1:0] m_tdata
);

    logic          in_vld_reg;
    ttd_pkg::req_t in_req_reg;
    logic          out_vld_reg;
    ttd_pkg::res_t out_res_reg;
    ttd_pkg::res_t core_res;
    logic          go;

    // The core processes a request when the result register can take it.
    assign go       = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || go;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg.req_type   <= ttd_pkg::req_type_t'(s_tuser);
            in_req_reg.task_index <= s_tdata[1:0];
            in_req_reg.delay      <= s_tdata[33:2];
        end
    end

    ttd_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .req   (in_req_reg),
        .res   (core_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (go)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000, out_res_reg.status, out_res_reg.current_time,
                       out_res_reg.dispatched_task, out_res_reg.dispatched};

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import ttd_pkg::*;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Requests waiting to be offered, and results the dispatcher owes us.
    req_t pending_requests[$];
    res_t expected_results[$];

    // Shadow copy of the dispatcher state.
    time_t model_ticks;
    time_t model_due[NUM_TASKS];
    ptr_t  model_ptr;
    bit    model_busy;

    int    error_count = 0;
    int    tx_idle_pct = 0;
    int    rx_idle_pct = 0;
    int    hold_seq = 0;
    int    hold_seen = 0;
    int    hold_left = 0;
    bit    in_taken = 1'b0;
    req_t  next_req;
    req_t  taken_req;
    res_t  seen_res;
    res_t  want_res;

    tick_task_dispatcher u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic req_t build_request(req_type_t kind, logic [1:0] idx,
                                           logic [31:0] dly);
        req_t r;
        r.req_type   = kind;
        r.task_index = idx;
        r.delay      = dly;
        return r;
    endfunction

    // Mostly short delays so that tasks fall due quickly, plus full-range
    // values and values that wrap the due time around zero.
    function automatic logic [31:0] pick_delay();
        logic [31:0] d;
        case ($urandom_range(9))
            6:       d = '0;
            7:       d = $urandom;
            8:       d = 32'hFFFF_FFFF - $urandom_range(8);
            9:       d = 32'h1 << $urandom_range(31);
            default: d = $urandom_range(8);
        endcase
        return d;
    endfunction

    function automatic ptr_t next_slot(ptr_t p);
        return (p == ptr_t'(NUM_TASKS - 1)) ? ptr_t'(0) : ptr_t'(p + 1);
    endfunction

    // Apply one request to the shadow state and queue the result it yields.
    task automatic predict_dispatch(input req_t r);
        res_t e;
        e = '0;
        e.dispatched_task = model_ptr;
        case (r.req_type)
            REQ_TICK:
            begin
                model_ticks = model_ticks + 1;
            end
            REQ_POLL:
            begin
                if (model_busy)
                    e.status = 1'b1;
                else if (model_due[model_ptr] != '0 && model_ticks >= model_due[model_ptr])
                begin
                    e.dispatched = 1'b1;
                    model_busy   = 1'b1;
                end
                else
                    model_ptr = next_slot(model_ptr);
            end
            REQ_SCHED:
            begin
                e.dispatched_task = r.task_index;
                if (int'(r.task_index) >= NUM_TASKS)
                    e.status = 1'b1;
                else
                    model_due[r.task_index] = model_ticks + time_t'(r.delay);
            end
            default:
            begin
                if (!model_busy)
                    e.status = 1'b1;
                else
                begin
                    model_due[model_ptr] = (r.delay != '0) ? model_ticks + time_t'(r.delay)
                                                          : time_t'(0);
                    model_busy = 1'b0;
                    model_ptr  = next_slot(model_ptr);
                end
            end
        endcase
        e.current_time = model_ticks[31:0];
        expected_results.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
    endtask

    // Request driver: a new request goes out only once the previous one has
    // been taken, and the sender may insert idle cycles.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                next_req = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_req.req_type;
                s_tdata  <= {6'b0, next_req.delay, next_req.task_index};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver: a requested long hold-off, otherwise random stalls.
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= 400;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Monitor: predict on every accepted request, check every accepted result.
    always @(posedge clk)
    begin
        in_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            taken_req.req_type   = req_type_t'(s_tuser[1:0]);
            taken_req.task_index = s_tdata[1:0];
            taken_req.delay      = s_tdata[33:2];
            predict_dispatch(taken_req);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_res = res_t'(m_tdata[35:0]);
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            else
            begin
                want_res = expected_results.pop_front();
                if (seen_res.dispatched !== want_res.dispatched)
                    report_mismatch("dispatched", seen_res.dispatched, want_res.dispatched);
                if (seen_res.dispatched_task !== want_res.dispatched_task)
                    report_mismatch("dispatched_task", seen_res.dispatched_task,
                                    want_res.dispatched_task);
                if (seen_res.current_time !== want_res.current_time)
                    report_mismatch("current_time", seen_res.current_time,
                                    want_res.current_time);
                if (seen_res.status !== want_res.status)
                    report_mismatch("status", seen_res.status, want_res.status);
            end
        end
    end

    // Wait until every request has gone out and every result has come back.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_requests.size() != 0 || expected_results.size() != 0 ||
               (s_tvalid && !in_taken))
            @(negedge clk);
    endtask

    // Short directed run over busy polls, stray dones, wrapped sums and
    // pointer wrap.
    task automatic load_directed();
        pending_requests.push_back(build_request(REQ_SCHED, 2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_POLL,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_POLL,  2'd3, 32'hFFFF_FFFF));
        pending_requests.push_back(build_request(REQ_SCHED, 2'd0, 32'd5));
        pending_requests.push_back(build_request(REQ_TICK,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_DONE,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_DONE,  2'd1, 32'd7));
        pending_requests.push_back(build_request(REQ_SCHED, 2'd1, 32'hFFFF_FFFE));
        pending_requests.push_back(build_request(REQ_SCHED, 2'd2, 32'hFFFF_FFFF));
        pending_requests.push_back(build_request(REQ_SCHED, 2'd3, 32'h8000_0000));
        pending_requests.push_back(build_request(REQ_POLL,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_POLL,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_DONE,  2'd2, 32'd3));
        pending_requests.push_back(build_request(REQ_POLL,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_POLL,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_POLL,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_POLL,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_TICK,  2'd3, 32'hFFFF_FFFF));
        pending_requests.push_back(build_request(REQ_TICK,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_TICK,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_POLL,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_POLL,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_POLL,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_POLL,  2'd0, 32'd0));
        pending_requests.push_back(build_request(REQ_DONE,  2'd3, 32'hFFFF_FFFF));
    endtask

    // Mostly well-formed rounds (schedule, ticks, polls, done) with random
    // content; the rest are single random requests.
    task automatic load_random(input int count);
        int start;
        int n;
        start = pending_requests.size();
        while (pending_requests.size() - start < count)
        begin
            if ($urandom_range(9) < 7)
            begin
                pending_requests.push_back(build_request(REQ_SCHED, 2'($urandom_range(3)),
                                                         pick_delay()));
                n = $urandom_range(4);
                repeat (n)
                    pending_requests.push_back(build_request(REQ_TICK, 2'($urandom_range(3)),
                                                             $urandom));
                n = $urandom_range(1, 5);
                repeat (n)
                    pending_requests.push_back(build_request(REQ_POLL, 2'($urandom_range(3)),
                                                             $urandom));
                pending_requests.push_back(build_request(REQ_DONE, 2'($urandom_range(3)),
                                                         pick_delay()));
            end
            else
                pending_requests.push_back(build_request(req_type_t'($urandom_range(3)),
                                                         2'($urandom_range(3)),
                                                         pick_delay()));
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int count,
                             input bit with_hold);
        @(posedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        load_random(count);
        if (with_hold)
            hold_seq++;
        wait_idle();
    endtask

    // Main sequence: reset, directed requests, then three random phases.
    initial
    begin
        model_ticks = 1;
        foreach (model_due[i])
            model_due[i] = '0;
        model_ptr  = '0;
        model_busy = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        load_directed();
        wait_idle();

        run_phase(32, 77, 600, 1'b1);
        run_phase(77, 32, 600, 1'b0);
        run_phase(0, 0, 600, 1'b1);

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ttd_pkg.sv
rtl/ttd_core.sv
rtl/tick_task_dispatcher.sv
test/tb.sv
